// ===== rtl/vector3_arithmetic_unit_defines.svh =====
// assertion macros for the vector arithmetic unit
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vector3_arithmetic_unit assertion failed");

// next-cycle implication, disabled during reset
`define VAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vector3_arithmetic_unit assertion failed");

`endif

// ===== rtl/vau_pkg.sv =====
// shared operation codes, control type and constants of the vector arithmetic unit
package vau_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_CROSS = 3'd3;
    localparam logic [2:0] OP_DOT   = 3'd4;
    localparam logic [2:0] OP_MAG   = 3'd5;

    // root bits resolved per square root stage
    localparam int ROOT_STEPS = 2;

    typedef struct packed {
        logic       valid;
        logic [2:0] op;
    } t_ctl;

endpackage

// ===== rtl/vau_in_if.sv =====
// request channel interface of the vector arithmetic unit
interface vau_in_if #(
    parameter int COMPONENT_BITS = 16
);
    logic                             valid;
    logic                             ready;
    logic [2:0]                       operation;
    logic signed [COMPONENT_BITS-1:0] a_x;
    logic signed [COMPONENT_BITS-1:0] a_y;
    logic signed [COMPONENT_BITS-1:0] a_z;
    logic signed [COMPONENT_BITS-1:0] b_x;
    logic signed [COMPONENT_BITS-1:0] b_y;
    logic signed [COMPONENT_BITS-1:0] b_z;
    logic signed [COMPONENT_BITS-1:0] factor;

    modport source (
        output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, factor,
        input  ready
    );

    modport sink (
        input  valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, factor,
        output ready
    );
endinterface

// ===== rtl/vau_out_if.sv =====
// result channel interface of the vector arithmetic unit
interface vau_out_if #(
    parameter int COMPONENT_BITS = 16
);
    logic                               valid;
    logic                               ready;
    logic signed [COMPONENT_BITS-1:0]   r_x;
    logic signed [COMPONENT_BITS-1:0]   r_y;
    logic signed [COMPONENT_BITS-1:0]   r_z;
    logic signed [2*COMPONENT_BITS:0]   scalar_out;
    logic                               saturated;

    modport source (
        output valid, r_x, r_y, r_z, scalar_out, saturated,
        input  ready
    );

    modport sink (
        input  valid, r_x, r_y, r_z, scalar_out, saturated,
        output ready
    );
endinterface

// ===== rtl/vau_mul.sv =====
// first stage: operand selection, six multipliers and component add or subtract
module vau_mul #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [2:0]                         i_op,
    input  logic signed [COMPONENT_BITS-1:0]   i_a_x,
    input  logic signed [COMPONENT_BITS-1:0]   i_a_y,
    input  logic signed [COMPONENT_BITS-1:0]   i_a_z,
    input  logic signed [COMPONENT_BITS-1:0]   i_b_x,
    input  logic signed [COMPONENT_BITS-1:0]   i_b_y,
    input  logic signed [COMPONENT_BITS-1:0]   i_b_z,
    input  logic signed [COMPONENT_BITS-1:0]   i_factor,
    output vau_pkg::t_ctl                      o_ctl,
    output logic signed [2*COMPONENT_BITS-1:0] o_prod [6],
    output logic signed [COMPONENT_BITS:0]     o_lin [3]
);
    import vau_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int PW = 2 * COMPONENT_BITS;

    logic signed [CB-1:0] w_a  [3];
    logic signed [CB-1:0] w_b  [3];
    logic signed [CB-1:0] w_ma [6];
    logic signed [CB-1:0] w_mb [6];

    logic signed [PW-1:0] n_prod [6];
    logic signed [CB:0]   n_lin  [3];

    t_ctl                 r_ctl;
    logic signed [PW-1:0] r_prod [6];
    logic signed [CB:0]   r_lin  [3];

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_a[2] = i_a_z;
    assign w_b[0] = i_b_x;
    assign w_b[1] = i_b_y;
    assign w_b[2] = i_b_z;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_ma[k] = '0;
            w_mb[k] = '0;
        end
        unique case (i_op) inside
            OP_ADD, OP_SUB: begin
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    w_ma[i] = w_a[i];
                    w_mb[i] = i_factor;
                end
            end
            OP_CROSS: begin
                w_ma[0] = w_a[1]; w_mb[0] = w_b[2];
                w_ma[1] = w_a[2]; w_mb[1] = w_b[1];
                w_ma[2] = w_a[2]; w_mb[2] = w_b[0];
                w_ma[3] = w_a[0]; w_mb[3] = w_b[2];
                w_ma[4] = w_a[0]; w_mb[4] = w_b[1];
                w_ma[5] = w_a[1]; w_mb[5] = w_b[0];
            end
            OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    w_ma[i] = w_a[i];
                    w_mb[i] = w_b[i];
                end
            end
            OP_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    w_ma[i] = w_a[i];
                    w_mb[i] = w_a[i];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_prod[k] = w_ma[k] * w_mb[k];
        end
        for (int i = 0; i < 3; i++) begin
            if (i_op == OP_SUB) begin
                n_lin[i] = (CB+1)'(w_a[i]) - (CB+1)'(w_b[i]);
            end else begin
                n_lin[i] = (CB+1)'(w_a[i]) + (CB+1)'(w_b[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= '{valid: i_valid, op: i_op};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_lin  <= n_lin;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_prod = r_prod;
    assign o_lin  = r_lin;

endmodule

// ===== rtl/vau_comb.sv =====
// second and third stages: product combine, dot sum, rounding and saturation
module vau_comb #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRAC_BITS      = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [1:0]                         i_en,
    input  vau_pkg::t_ctl                      i_ctl,
    input  logic signed [2*COMPONENT_BITS-1:0] i_prod [6],
    input  logic signed [COMPONENT_BITS:0]     i_lin [3],
    output logic [1:0]                         o_vld,
    output vau_pkg::t_ctl                      o_ctl,
    output logic signed [COMPONENT_BITS-1:0]   o_r [3],
    output logic                               o_flag,
    output logic signed [2*COMPONENT_BITS:0]   o_sum
);
    import vau_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int WP = 2 * COMPONENT_BITS + 1;
    localparam logic signed [WP-1:0] HALF = WP'((2**FRAC_BITS) / 2);

    logic signed [WP-1:0] n2_pre [3];
    logic signed [WP-1:0] n2_sum;

    t_ctl                 r2_ctl;
    logic signed [WP-1:0] r2_pre [3];
    logic signed [WP-1:0] r2_sum;

    logic signed [CB-1:0] n3_r [3];
    logic                 n3_flag;

    t_ctl                 r3_ctl;
    logic signed [CB-1:0] r3_r [3];
    logic                 r3_flag;
    logic signed [WP-1:0] r3_sum;

    // stage 2: cross differences, scale products, linear results and three-term sum
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (i_ctl.op) inside
                OP_ADD, OP_SUB: n2_pre[i] = WP'(i_lin[i]);
                OP_SCALE:       n2_pre[i] = WP'(i_prod[i]);
                OP_CROSS:       n2_pre[i] = WP'(i_prod[2*i]) - WP'(i_prod[2*i+1]);
                OP_DOT, OP_MAG: n2_pre[i] = '0;
                default:        n2_pre[i] = '0;
            endcase
        end
        n2_sum = WP'(i_prod[0]) + WP'(i_prod[1]) + WP'(i_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_en[0]) begin
            r2_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r2_pre <= n2_pre;
            r2_sum <= n2_sum;
        end
    end

    // stage 3: round half up for scale and cross, then clip vector results to the component range
    always_comb begin
        logic                 w_vec;
        logic                 w_rnd;
        logic signed [WP-1:0] w_x;
        logic                 w_inr;
        logic signed [CB-1:0] w_sat;
        w_vec = (r2_ctl.op == OP_ADD) || (r2_ctl.op == OP_SUB) ||
                (r2_ctl.op == OP_SCALE) || (r2_ctl.op == OP_CROSS);
        w_rnd = (r2_ctl.op == OP_SCALE) || (r2_ctl.op == OP_CROSS);
        n3_flag = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_x   = w_rnd ? ((r2_pre[i] + HALF) >>> FRAC_BITS) : r2_pre[i];
            w_inr = (&w_x[WP-1:CB-1]) | ~(|w_x[WP-1:CB-1]);
            w_sat = w_inr ? w_x[CB-1:0] : {w_x[WP-1], {(CB-1){~w_x[WP-1]}}};
            n3_r[i] = w_vec ? w_sat : '0;
            n3_flag = n3_flag | (w_vec & ~w_inr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (i_en[1]) begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r3_r    <= n3_r;
            r3_flag <= n3_flag;
            r3_sum  <= r2_sum;
        end
    end

    assign o_vld  = {r3_ctl.valid, r2_ctl.valid};
    assign o_ctl  = r3_ctl;
    assign o_r    = r3_r;
    assign o_flag = r3_flag;
    assign o_sum  = r3_sum;

endmodule

// ===== rtl/vau_sqrt.sv =====
// pipelined digit-by-digit integer square root with a carried passenger word
module vau_sqrt #(
    parameter int COMPONENT_BITS = 16,
    parameter int PASS_W         = 82
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [(COMPONENT_BITS+1)/2-1:0]         i_en,
    input  vau_pkg::t_ctl                           i_ctl,
    input  logic [2*COMPONENT_BITS-1:0]             i_rad,
    input  logic [PASS_W-1:0]                       i_pass,
    output logic [(COMPONENT_BITS+1)/2-1:0]         o_vld,
    output vau_pkg::t_ctl                           o_ctl,
    output logic [COMPONENT_BITS-1:0]               o_root,
    output logic [PASS_W-1:0]                       o_pass
);
    import vau_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int NS = (COMPONENT_BITS + 1) / 2;
    localparam int RW = COMPONENT_BITS + 2;
    localparam int XW = 2 * COMPONENT_BITS;

    t_ctl              r_ctl  [NS];
    logic [XW-1:0]     r_rad  [NS];
    logic [RW-1:0]     r_rem  [NS];
    logic [CB-1:0]     r_q    [NS];
    logic [PASS_W-1:0] r_pass [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        t_ctl              w_ctl;
        logic [XW-1:0]     w_rad;
        logic [PASS_W-1:0] w_pass;
        logic [RW-1:0]     w_rem [ROOT_STEPS+1];
        logic [CB-1:0]     w_q   [ROOT_STEPS+1];

        if (k == 0) begin : g_first
            assign w_ctl    = i_ctl;
            assign w_rad    = i_rad;
            assign w_pass   = i_pass;
            assign w_rem[0] = '0;
            assign w_q[0]   = '0;
        end else begin : g_next
            assign w_ctl    = r_ctl[k-1];
            assign w_rad    = r_rad[k-1];
            assign w_pass   = r_pass[k-1];
            assign w_rem[0] = r_rem[k-1];
            assign w_q[0]   = r_q[k-1];
        end

        for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
            localparam int IDX = CB - 1 - (ROOT_STEPS * k + j);
            if (IDX >= 0) begin : g_on
                logic [RW-1:0] w_sh;
                logic [RW-1:0] w_trial;
                logic          w_ge;
                assign w_sh       = {w_rem[j][CB-1:0], w_rad[2*IDX+1 -: 2]};
                assign w_trial    = {w_q[j], 2'b01};
                assign w_ge       = (w_sh >= w_trial);
                assign w_rem[j+1] = w_ge ? (w_sh - w_trial) : w_sh;
                assign w_q[j+1]   = {w_q[j][CB-2:0], w_ge};
            end else begin : g_off
                assign w_rem[j+1] = w_rem[j];
                assign w_q[j+1]   = w_q[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en[k]) begin
                r_ctl[k] <= w_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rad[k]  <= w_rad;
                r_rem[k]  <= w_rem[ROOT_STEPS];
                r_q[k]    <= w_q[ROOT_STEPS];
                r_pass[k] <= w_pass;
            end
        end

        assign o_vld[k] = r_ctl[k].valid;
    end

    assign o_ctl  = r_ctl[NS-1];
    assign o_root = r_q[NS-1];
    assign o_pass = r_pass[NS-1];

endmodule

// ===== rtl/vector3_arithmetic_unit.sv =====
// top level of the pipelined three-component fixed-point vector arithmetic unit
//
//  channel   direction  transaction contents
//  i_req     in         operation, a_x a_y a_z, b_x b_y b_z, factor
//  o_rsp     out        r_x r_y r_z, scalar_out, saturated
//
// one transaction per cycle while the output is not stalled; results pass the multiply, combine,
// square root and output registers in order, the square root pipeline resolving two root bits per stage
// every stage holds its own valid bit and loads when it is empty or the next stage moves,
// so bubbles close up and a stalled output only stops the stages behind it
// reset clears only the valid bits and operation codes
`include "vector3_arithmetic_unit_defines.svh"

module vector3_arithmetic_unit #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRAC_BITS      = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vau_in_if.sink           i_req,
    vau_out_if.source        o_rsp
);
    import vau_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int SB     = 2 * COMPONENT_BITS + 1;
    localparam int NS     = (COMPONENT_BITS + 1) / 2;
    localparam int PASS_W = 3 * COMPONENT_BITS + 1 + SB;
    localparam logic signed [CB-1:0] SMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] SMIN = {1'b1, {(CB-1){1'b0}}};

    t_ctl                 m_ctl;
    logic signed [2*CB-1:0] m_prod [6];
    logic signed [CB:0]   m_lin [3];

    logic [1:0]           c_vld;
    t_ctl                 c_ctl;
    logic signed [CB-1:0] c_r [3];
    logic                 c_flag;
    logic signed [SB-1:0] c_sum;

    logic [NS-1:0]        s_vld;
    t_ctl                 s_ctl;
    logic [CB-1:0]        s_root;
    logic [PASS_W-1:0]    s_pass;
    logic [PASS_W-1:0]    w_pass;

    logic                 w_en1;
    logic [1:0]           w_en_c;
    logic [NS-1:0]        w_en_s;
    logic                 w_en_out;

    logic signed [SB-1:0] w_osum;
    logic signed [SB-1:0] n_scalar;

    logic                 r_out_valid;
    logic signed [CB-1:0] r_out_x;
    logic signed [CB-1:0] r_out_y;
    logic signed [CB-1:0] r_out_z;
    logic signed [SB-1:0] r_out_scalar;
    logic                 r_out_sat;

    logic                 w_chk_scalar;
    logic                 w_chk_clear;
    logic                 w_chk_limit;

    // stage load enables, from the output back to the input
    always_comb begin
        w_en_out       = !r_out_valid || o_rsp.ready;
        w_en_s[NS-1]   = !s_vld[NS-1] || w_en_out;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en_s[k] = !s_vld[k] || w_en_s[k+1];
        end
        w_en_c[1] = !c_vld[1] || w_en_s[0];
        w_en_c[0] = !c_vld[0] || w_en_c[1];
        w_en1     = !m_ctl.valid || w_en_c[0];
    end

    assign i_req.ready = w_en1;

    vau_mul #(
        .COMPONENT_BITS (CB)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en1),
        .i_valid  (i_req.valid),
        .i_op     (i_req.operation),
        .i_a_x    (i_req.a_x),
        .i_a_y    (i_req.a_y),
        .i_a_z    (i_req.a_z),
        .i_b_x    (i_req.b_x),
        .i_b_y    (i_req.b_y),
        .i_b_z    (i_req.b_z),
        .i_factor (i_req.factor),
        .o_ctl    (m_ctl),
        .o_prod   (m_prod),
        .o_lin    (m_lin)
    );

    vau_comb #(
        .COMPONENT_BITS (CB),
        .FRAC_BITS      (FRAC_BITS)
    ) u_comb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en_c),
        .i_ctl   (m_ctl),
        .i_prod  (m_prod),
        .i_lin   (m_lin),
        .o_vld   (c_vld),
        .o_ctl   (c_ctl),
        .o_r     (c_r),
        .o_flag  (c_flag),
        .o_sum   (c_sum)
    );

    assign w_pass = {c_r[0], c_r[1], c_r[2], c_flag, c_sum};

    vau_sqrt #(
        .COMPONENT_BITS (CB),
        .PASS_W         (PASS_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en_s),
        .i_ctl   (c_ctl),
        .i_rad   (c_sum[2*CB-1:0]),
        .i_pass  (w_pass),
        .o_vld   (s_vld),
        .o_ctl   (s_ctl),
        .o_root  (s_root),
        .o_pass  (s_pass)
    );

    assign w_osum = s_pass[SB-1:0];

    always_comb begin
        unique case (s_ctl.op) inside
            OP_DOT:                                 n_scalar = w_osum;
            OP_MAG:                                 n_scalar = SB'(s_root);
            OP_ADD, OP_SUB, OP_SCALE, OP_CROSS:     n_scalar = '0;
            default:                                n_scalar = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= s_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_x      <= s_pass[PASS_W-1 -: CB];
            r_out_y      <= s_pass[PASS_W-1-CB -: CB];
            r_out_z      <= s_pass[PASS_W-1-2*CB -: CB];
            r_out_sat    <= s_pass[SB];
            r_out_scalar <= n_scalar;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.r_x        = r_out_x;
    assign o_rsp.r_y        = r_out_y;
    assign o_rsp.r_z        = r_out_z;
    assign o_rsp.scalar_out = r_out_scalar;
    assign o_rsp.saturated  = r_out_sat;

    assign w_chk_scalar = c_ctl.valid && (c_ctl.op == OP_DOT || c_ctl.op == OP_MAG);
    assign w_chk_clear  = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0) && !c_flag;
    assign w_chk_limit  = (r_out_x == SMAX) || (r_out_x == SMIN) ||
                          (r_out_y == SMAX) || (r_out_y == SMIN) ||
                          (r_out_z == SMAX) || (r_out_z == SMIN);

    // an accepted transaction always lands in the first stage
    `VAU_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_req.valid && i_req.ready, m_ctl.valid)

    // scalar operations leave the vector fields and the flag clear
    `VAU_ASSERT_IMPL(a_scalar_vec_zero, i_clk, i_rst_n, w_chk_scalar, w_chk_clear)

    // a raised flag means some component sits at a range limit
    `VAU_ASSERT_IMPL(a_sat_at_limit, i_clk, i_rst_n, r_out_valid && r_out_sat, w_chk_limit)

endmodule

// ===== test/vector3_arithmetic_unit_tb.sv =====
// self-checking testbench for the three-component vector arithmetic unit
`timescale 1ns / 100ps

module vector3_arithmetic_unit_tb;
    import vau_pkg::*;

    localparam int COMPONENT_BITS = 16;
    localparam int FRAC_BITS      = 8;
    localparam longint COMP_MAX   = (64'sd1 <<< (COMPONENT_BITS - 1)) - 1;
    localparam longint COMP_MIN   = -COMP_MAX - 1;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic signed [15:0] Q_MAX  = 16'sh7fff;
    localparam logic signed [15:0] Q_MIN  = -16'sh8000;
    localparam logic signed [15:0] Q_ONE  = 16'sh0100;
    localparam logic signed [15:0] Q_HALF = 16'sh0080;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] factor;
    } t_vec_req;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [32:0] scalar;
        logic               sat;
    } t_vec_rsp;

    logic i_clk;
    logic i_rst_n = 1'b0;

    vau_in_if  #(.COMPONENT_BITS(COMPONENT_BITS)) req_if ();
    vau_out_if #(.COMPONENT_BITS(COMPONENT_BITS)) rsp_if ();

    vector3_arithmetic_unit #(
        .COMPONENT_BITS(COMPONENT_BITS),
        .FRAC_BITS     (FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_vec_req pending_requests [$];
    t_vec_rsp awaited_results  [$];
    t_vec_req on_bus;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       load_phase    = 0;
    logic     rsp_hold      = 1'b0;
    int       mismatch_count = 0;

    function automatic t_vec_rsp vector_result(t_vec_req q);
        longint a [3];
        longint b [3];
        longint f;
        longint comp [3];
        longint acc;
        longint root;
        longint trial;
        t_vec_rsp r;
        a[0] = $signed(q.a_x);
        a[1] = $signed(q.a_y);
        a[2] = $signed(q.a_z);
        b[0] = $signed(q.b_x);
        b[1] = $signed(q.b_y);
        b[2] = $signed(q.b_z);
        f    = $signed(q.factor);
        for (int i = 0; i < 3; i++) comp[i] = 0;
        acc  = 0;
        root = 0;
        r    = '0;
        case (q.op)
            OP_ADD: begin
                for (int i = 0; i < 3; i++) comp[i] = a[i] + b[i];
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) comp[i] = a[i] - b[i];
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) comp[i] = (a[i] * f + ROUND_HALF) >>> FRAC_BITS;
            end
            OP_CROSS: begin
                comp[0] = (a[1] * b[2] - a[2] * b[1] + ROUND_HALF) >>> FRAC_BITS;
                comp[1] = (a[2] * b[0] - a[0] * b[2] + ROUND_HALF) >>> FRAC_BITS;
                comp[2] = (a[0] * b[1] - a[1] * b[0] + ROUND_HALF) >>> FRAC_BITS;
            end
            OP_DOT: begin
                for (int i = 0; i < 3; i++) acc += a[i] * b[i];
                r.scalar = acc[32:0];
            end
            OP_MAG: begin
                for (int i = 0; i < 3; i++) acc += a[i] * a[i];
                // floor root, one bit at a time from the top
                for (int k = 20; k >= 0; k--) begin
                    trial = root | (64'sd1 <<< k);
                    if (trial * trial <= acc) root = trial;
                end
                r.scalar = root[32:0];
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            if (comp[i] > COMP_MAX) begin
                comp[i] = COMP_MAX;
                r.sat   = 1'b1;
            end else if (comp[i] < COMP_MIN) begin
                comp[i] = COMP_MIN;
                r.sat   = 1'b1;
            end
        end
        r.r_x = comp[0][15:0];
        r.r_y = comp[1][15:0];
        r.r_z = comp[2][15:0];
        return r;
    endfunction

    function automatic t_vec_req make_req(logic [2:0] op,
                                          logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] az, logic signed [15:0] bx,
                                          logic signed [15:0] by, logic signed [15:0] bz,
                                          logic signed [15:0] f);
        t_vec_req q;
        q.op     = op;
        q.a_x    = ax;
        q.a_y    = ay;
        q.a_z    = az;
        q.b_x    = bx;
        q.b_y    = by;
        q.b_z    = bz;
        q.factor = f;
        return q;
    endfunction

    // half full range, half small values that mostly stay clear of clipping
    function automatic logic signed [15:0] random_component();
        logic signed [15:0] v;
        if ($urandom_range(1) == 1) v = 16'($urandom);
        else v = 16'($urandom_range(4095)) - 16'sd2048;
        return v;
    endfunction

    task automatic queue_random(int count);
        logic [2:0] op;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 6) op = 3'($urandom_range(7, 6));
            else op = 3'($urandom_range(5));
            pending_requests.push_back(make_req(op, random_component(), random_component(),
                random_component(), random_component(), random_component(),
                random_component(), random_component()));
        end
    endtask

    task automatic drain_requests();
        while (pending_requests.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        req_if.valid     = 1'b0;
        req_if.operation = '0;
        req_if.a_x       = '0;
        req_if.a_y       = '0;
        req_if.a_z       = '0;
        req_if.b_x       = '0;
        req_if.b_y       = '0;
        req_if.b_z       = '0;
        req_if.factor    = '0;
        rsp_if.ready     = 1'b0;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) awaited_results.push_back(vector_result(on_bus));
            if (!req_if.valid || req_if.ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_requests.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.operation <= on_bus.op;
                    req_if.a_x       <= on_bus.a_x;
                    req_if.a_y       <= on_bus.a_y;
                    req_if.a_z       <= on_bus.a_z;
                    req_if.b_x       <= on_bus.b_x;
                    req_if.b_y       <= on_bus.b_y;
                    req_if.b_z       <= on_bus.b_z;
                    req_if.factor    <= on_bus.factor;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_vec_rsp got;
        t_vec_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.r_x    = rsp_if.r_x;
            got.r_y    = rsp_if.r_y;
            got.r_z    = rsp_if.r_z;
            got.scalar = rsp_if.scalar_out;
            got.sat    = rsp_if.saturated;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: transaction with none expected: r=(%0d %0d %0d) s=%0d sat=%0b",
                             $realtime, got.r_x, got.r_y, got.r_z, got.scalar, got.sat);
            end else begin
                want = awaited_results.pop_front();
                if (got.r_x !== want.r_x || got.r_y !== want.r_y || got.r_z !== want.r_z
                    || got.scalar !== want.scalar || got.sat !== want.sat) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: expected r=(%0d %0d %0d) s=%0d sat=%0b", $realtime,
                                 want.r_x, want.r_y, want.r_z, want.scalar, want.sat);
                        $display("%0t: actual   r=(%0d %0d %0d) s=%0d sat=%0b", $realtime,
                                 got.r_x, got.r_y, got.r_z, got.scalar, got.sat);
                    end
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        while (load_phase != 2) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (150) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("** vector3_arithmetic_unit: FAILED **");
        $finish;
    end

    initial begin
        int guard;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clipping at both ends
        pending_requests.push_back(make_req(OP_ADD, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_ONE, Q_MIN, 0));
        pending_requests.push_back(make_req(OP_ADD, Q_ONE, -Q_ONE, 16'sh1234, Q_HALF, Q_ONE,
                                            -16'sh0234, Q_MAX));
        pending_requests.push_back(make_req(OP_SUB, Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN, Q_MIN, 0));
        pending_requests.push_back(make_req(OP_SUB, Q_ONE, 0, -Q_ONE, Q_HALF, Q_ONE, -Q_ONE, 0));
        // rounding of exact halves, both signs
        pending_requests.push_back(make_req(OP_SCALE, 16'sd1, -16'sd1, 16'sd3, 0, 0, 0, Q_HALF));
        pending_requests.push_back(make_req(OP_SCALE, Q_MAX, Q_MIN, Q_ONE, 0, 0, 0, Q_MAX));
        pending_requests.push_back(make_req(OP_SCALE, Q_MIN, Q_MAX, -Q_ONE, 0, 0, 0, Q_MIN));
        pending_requests.push_back(make_req(OP_SCALE, Q_ONE, -Q_HALF, 16'sh0321, 0, 0, 0, Q_ONE));
        pending_requests.push_back(make_req(OP_SCALE, Q_MAX, Q_MIN, 16'sh0777, Q_MAX, Q_MIN,
                                            Q_MAX, 0));
        // cross product must use the original components of a
        pending_requests.push_back(make_req(OP_CROSS, Q_ONE, 0, 0, 0, Q_ONE, 0, 0));
        pending_requests.push_back(make_req(OP_CROSS, 16'sh0200, 16'sh0300, 16'sh0400,
                                            16'sh0500, 16'sh0600, 16'sh0700, 0));
        pending_requests.push_back(make_req(OP_CROSS, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN,
                                            Q_MAX, 0));
        pending_requests.push_back(make_req(OP_CROSS, 16'sd1, 16'sd1, -16'sd1, 16'sd128,
                                            -16'sd128, 16'sd1, 0));
        pending_requests.push_back(make_req(OP_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0));
        pending_requests.push_back(make_req(OP_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0));
        pending_requests.push_back(make_req(OP_DOT, Q_ONE, -Q_HALF, 16'sd1, Q_ONE, Q_ONE,
                                            -16'sd1, Q_MAX));
        pending_requests.push_back(make_req(OP_MAG, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0));
        pending_requests.push_back(make_req(OP_MAG, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        pending_requests.push_back(make_req(OP_MAG, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0));
        pending_requests.push_back(make_req(OP_MAG, 16'sh0300, -16'sh0400, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(OP_SPARE_6, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MIN,
                                            Q_ONE, Q_MAX));
        pending_requests.push_back(make_req(OP_SPARE_7, Q_MIN, Q_MAX, -Q_ONE, Q_MIN, Q_MAX,
                                            -Q_ONE, Q_MIN));
        drain_requests();

        send_idle_pct <= 16;
        recv_idle_pct <= 62;
        queue_random(380);
        drain_requests();

        send_idle_pct <= 62;
        recv_idle_pct <= 16;
        load_phase    <= 1;
        queue_random(380);
        drain_requests();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        load_phase    <= 2;
        queue_random(380);
        drain_requests();

        guard = 0;
        while ((awaited_results.size() > 0 || req_if.valid) && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_results.size() == 0 && !req_if.valid) begin
            $display("** vector3_arithmetic_unit: PASSED **");
        end else begin
            $display("** vector3_arithmetic_unit: FAILED **");
        end
        $finish;
    end

endmodule
